### rtl/lhg_pkg.sv
`default_nettype none

package lhg_pkg;

    localparam int CELLS_PER_M = 5;

    localparam int COORD_W    = 16;
    localparam int QUERY_W    = 8;
    localparam int GEO_W      = 18;
    localparam int RANGE_W    = 5;
    localparam int CELL_SZ_W  = 8;
    localparam int THR_W      = 12;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 12;

    localparam int RECIP_SHIFT = 24;
    localparam int RECIP_W     = RECIP_SHIFT + 1;
    localparam int PROD_W      = COORD_W + RECIP_W;
    localparam int QUOT_W      = COORD_W + 1;
    localparam int DIV_CNT_W   = $clog2(RECIP_W);

    localparam int S_DATA_W = 64;
    localparam int M_DATA_W = 40;

    localparam logic [RANGE_W-1:0]   RANGE_RST = RANGE_W'(10);
    localparam logic [CELL_SZ_W-1:0] CELL_RST  = CELL_SZ_W'(20);
    localparam logic [THR_W-1:0]     THR_RST   = THR_W'(20);

    typedef enum logic {
        OP_INSERT = 1'b0,
        OP_READ   = 1'b1
    } t_opcode;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_RANGE_FRONT = 3'd0,
        CFG_RANGE_BACK  = 3'd1,
        CFG_RANGE_LEFT  = 3'd2,
        CFG_RANGE_RIGHT = 3'd3,
        CFG_CELL_SIZE   = 3'd4,
        CFG_THRESHOLD   = 3'd5
    } t_cfg_reg;

    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_MUL,
        ST_ADDR,
        ST_UPD
    } t_state;

    typedef struct packed {
        logic               valid;
        logic [COORD_W-1:0] hi_cm;
        logic [COORD_W-1:0] lo_cm;
    } t_cell;

endpackage

`default_nettype wire

### rtl/lidar_height_grid_obstacle_map_unit.sv
// Lidar height grid: bins points into a cell grid and keeps per-cell min/max height.
// Slave stream: tuser = opcode (insert point / read cell); tdata carries x, y, z in cm
// and the query row and column. Master stream: one result per request, tuser = in_grid,
// tdata = cell valid, min height, max height, obstacle flag.
// Config channel: index selects the register, data is taken in its low bits; write
// only while no request is in flight.
// After a request is accepted it passes through states MUL, ADDR and UPD: reciprocal multiply
// for the cell binning, cell memory read, then update and write-back. No new request is
// taken until the single read-modify-write pass through the cell memory is done. A new
// request is taken while a result still waits in the output register; if the receiver
// stalls, the next request holds in its update step.
// After reset the cell memory is swept clear, one entry a cycle, all 2**(ROW_AW+COL_AW)
// entries, 65536 at the default size, with tready low. A write of the cell size
// recomputes the divisor reciprocal, tready low meanwhile.
`default_nettype none

module lidar_height_grid_obstacle_map_unit
    import lhg_pkg::*;
#(
    parameter int GRID_ROWS = 256,
    parameter int GRID_COLS = 256
) (
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    input  wire logic                  i_s_tvalid,
    output logic                       o_s_tready,
    // [15:0] x_cm, [31:16] y_cm, [47:32] z_cm, [55:48] query_row, [63:56] query_col
    input  wire logic [S_DATA_W-1:0]   i_s_tdata,
    // [0] opcode
    input  wire logic                  i_s_tuser,
    output logic                       o_m_tvalid,
    input  wire logic                  i_m_tready,
    // [0] cell_valid, [16:1] min_height_cm, [32:17] max_height_cm, [33] obstacle
    output logic [M_DATA_W-1:0]        o_m_tdata,
    // [0] in_grid
    output logic                       o_m_tuser,
    input  wire logic                  i_cfg_valid,
    output logic                       o_cfg_ready,
    input  wire logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  wire logic [CFG_DATA_W-1:0] i_cfg_data
);

    localparam int ROW_AW    = $clog2(GRID_ROWS);
    localparam int COL_AW    = $clog2(GRID_COLS);
    localparam int ADDR_W    = ROW_AW + COL_AW;
    localparam int MEM_DEPTH = 1 << ADDR_W;
    localparam logic [GEO_W-1:0] ROWS_LIM = GEO_W'(GRID_ROWS);
    localparam logic [GEO_W-1:0] COLS_LIM = GEO_W'(GRID_COLS);

    t_state r_state, n_state;

    logic [RANGE_W-1:0]   r_range_front, r_range_back, r_range_left, r_range_right;
    logic [CELL_SZ_W-1:0] r_cell_size;
    logic [THR_W-1:0]     r_threshold;

    logic                 r_div_busy;
    logic [DIV_CNT_W-1:0] r_div_cnt;
    logic [CELL_SZ_W-1:0] r_div_rem;
    logic [RECIP_W-2:0]   r_div_q;
    logic [RECIP_W-1:0]   r_recip;
    logic [CELL_SZ_W:0]   n_div_sh;
    logic                 n_div_bit;

    logic [ADDR_W-1:0]    r_clr_addr;

    t_opcode              r_op;
    logic [COORD_W-1:0]   r_x_abs, r_y_abs, r_z;
    logic                 r_x_neg, r_y_neg;
    logic [QUERY_W-1:0]   r_qrow, r_qcol;
    logic [PROD_W-1:0]    r_prod_x, r_prod_y;

    logic [GEO_W-1:0]     n_rows_used, n_cols_used, n_span_r, n_span_c;
    logic [GEO_W-1:0]     n_qx, n_qy, n_row, n_col;
    logic                 n_hit;
    logic [ADDR_W-1:0]    n_addr;

    logic                 r_hit;
    logic [ADDR_W-1:0]    r_addr;
    t_cell                r_cells [MEM_DEPTH];
    t_cell                r_rdata;

    logic                 s_ready, mem_re, upd_fire, clr_we, mem_we;
    logic [ADDR_W-1:0]    mem_waddr;
    t_cell                mem_wdata;

    logic [COORD_W-1:0]   n_new_lo, n_new_hi, n_res_lo, n_res_hi;
    logic                 n_res_valid, n_obstacle;
    logic signed [GEO_W-1:0] n_spread;

    logic                 r_out_valid, r_out_in_grid, r_out_cell_valid, r_out_obstacle;
    logic [COORD_W-1:0]   r_out_lo, r_out_hi;

    // configuration
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_range_front <= RANGE_RST;
            r_range_back  <= RANGE_RST;
            r_range_left  <= RANGE_RST;
            r_range_right <= RANGE_RST;
            r_cell_size   <= CELL_RST;
            r_threshold   <= THR_RST;
        end else if (i_cfg_valid) begin
            unique case (t_cfg_reg'(i_cfg_index))
                CFG_RANGE_FRONT: r_range_front <= i_cfg_data[RANGE_W-1:0];
                CFG_RANGE_BACK:  r_range_back  <= i_cfg_data[RANGE_W-1:0];
                CFG_RANGE_LEFT:  r_range_left  <= i_cfg_data[RANGE_W-1:0];
                CFG_RANGE_RIGHT: r_range_right <= i_cfg_data[RANGE_W-1:0];
                CFG_CELL_SIZE:   r_cell_size   <= i_cfg_data[CELL_SZ_W-1:0];
                CFG_THRESHOLD:   r_threshold   <= i_cfg_data[THR_W-1:0];
                default: ;
            endcase
        end
    end

    assign o_cfg_ready = 1'b1;

    // reciprocal floor(2**24 / cell_size) + 1, one quotient bit per cycle
    assign n_div_sh  = {r_div_rem, (r_div_cnt == DIV_CNT_W'(RECIP_SHIFT))};
    assign n_div_bit = (n_div_sh >= {1'b0, r_cell_size});

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_div_busy <= 1'b1;
            r_div_cnt  <= DIV_CNT_W'(RECIP_SHIFT);
            r_div_rem  <= '0;
        end else if (i_cfg_valid && (t_cfg_reg'(i_cfg_index) == CFG_CELL_SIZE)) begin
            r_div_busy <= 1'b1;
            r_div_cnt  <= DIV_CNT_W'(RECIP_SHIFT);
            r_div_rem  <= '0;
        end else if (r_div_busy) begin
            r_div_rem <= n_div_bit ? CELL_SZ_W'(n_div_sh - {1'b0, r_cell_size})
                                   : n_div_sh[CELL_SZ_W-1:0];
            r_div_cnt <= r_div_cnt - 1'b1;
            if (r_div_cnt == '0) begin
                r_div_busy <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_div_busy) begin
            r_div_q <= {r_div_q[RECIP_W-3:0], n_div_bit};
            if (r_div_cnt == '0) begin
                r_recip <= {r_div_q, n_div_bit} + RECIP_W'(1);
            end
        end
    end

    // sequencer
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_CLEAR;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state  = r_state;
        s_ready  = 1'b0;
        mem_re   = 1'b0;
        upd_fire = 1'b0;
        clr_we   = 1'b0;
        unique case (r_state)
            ST_CLEAR: begin
                clr_we = 1'b1;
                if (&r_clr_addr) begin
                    n_state = ST_IDLE;
                end
            end
            ST_IDLE: begin
                s_ready = !r_div_busy;
                if (i_s_tvalid && s_ready) begin
                    n_state = ST_MUL;
                end
            end
            ST_MUL: n_state = ST_ADDR;
            ST_ADDR: begin
                mem_re  = n_hit;
                n_state = ST_UPD;
            end
            ST_UPD: begin
                if (!r_out_valid || i_m_tready) begin
                    upd_fire = 1'b1;
                    n_state  = ST_IDLE;
                end
            end
            default: n_state = ST_CLEAR;
        endcase
    end

    assign o_s_tready = s_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_clr_addr <= '0;
        end else if (clr_we) begin
            r_clr_addr <= r_clr_addr + 1'b1;
        end
    end

    // capture request
    always_ff @(posedge i_clk) begin
        if (i_s_tvalid && s_ready) begin
            r_op    <= t_opcode'(i_s_tuser);
            r_x_neg <= i_s_tdata[15];
            r_y_neg <= i_s_tdata[31];
            r_x_abs <= i_s_tdata[15] ? (~i_s_tdata[15:0] + 1'b1) : i_s_tdata[15:0];
            r_y_abs <= i_s_tdata[31] ? (~i_s_tdata[31:16] + 1'b1) : i_s_tdata[31:16];
            r_z     <= i_s_tdata[47:32];
            r_qrow  <= i_s_tdata[55:48];
            r_qcol  <= i_s_tdata[63:56];
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_state == ST_MUL) begin
            r_prod_x <= PROD_W'(r_x_abs) * PROD_W'(r_recip);
            r_prod_y <= PROD_W'(r_y_abs) * PROD_W'(r_recip);
        end
    end

    // cell address and bounds
    always_comb begin
        n_span_r    = GEO_W'(CELLS_PER_M) * (GEO_W'(r_range_front) + GEO_W'(r_range_back));
        n_span_c    = GEO_W'(CELLS_PER_M) * (GEO_W'(r_range_left) + GEO_W'(r_range_right));
        n_rows_used = (n_span_r < ROWS_LIM) ? n_span_r : ROWS_LIM;
        n_cols_used = (n_span_c < COLS_LIM) ? n_span_c : COLS_LIM;
        n_qx = GEO_W'(r_prod_x[RECIP_SHIFT +: QUOT_W]);
        n_qy = GEO_W'(r_prod_y[RECIP_SHIFT +: QUOT_W]);
        if (r_x_neg) begin
            n_qx = -n_qx;
        end
        if (r_y_neg) begin
            n_qy = -n_qy;
        end
        if (r_op == OP_READ) begin
            n_row = GEO_W'(r_qrow);
            n_col = GEO_W'(r_qcol);
        end else begin
            n_row = GEO_W'(CELLS_PER_M) * GEO_W'(r_range_front) - GEO_W'(1) - n_qx;
            n_col = GEO_W'(CELLS_PER_M) * GEO_W'(r_range_left) - GEO_W'(1) - n_qy;
        end
        n_hit = !n_row[GEO_W-1] && !n_col[GEO_W-1]
                && (n_row < n_rows_used) && (n_col < n_cols_used)
                && ((r_op == OP_READ) || (r_cell_size != '0));
        n_addr = {n_row[ROW_AW-1:0], n_col[COL_AW-1:0]};
    end

    always_ff @(posedge i_clk) begin
        if (r_state == ST_ADDR) begin
            r_hit  <= n_hit;
            r_addr <= n_addr;
        end
    end

    // cell memory
    assign mem_we    = clr_we || (upd_fire && r_hit && (r_op == OP_INSERT));
    assign mem_waddr = clr_we ? r_clr_addr : r_addr;
    always_comb begin
        mem_wdata = '0;
        if (!clr_we) begin
            mem_wdata.valid = 1'b1;
            mem_wdata.hi_cm = n_new_hi;
            mem_wdata.lo_cm = n_new_lo;
        end
    end

    always_ff @(posedge i_clk) begin
        if (mem_re) begin
            r_rdata <= r_cells[n_addr];
        end
        if (mem_we) begin
            r_cells[mem_waddr] <= mem_wdata;
        end
    end

    // update and result
    always_comb begin
        n_new_lo = (!r_rdata.valid || ($signed(r_z) < $signed(r_rdata.lo_cm)))
                   ? r_z : r_rdata.lo_cm;
        n_new_hi = (!r_rdata.valid || ($signed(r_z) > $signed(r_rdata.hi_cm)))
                   ? r_z : r_rdata.hi_cm;
        n_res_valid = 1'b0;
        n_res_lo    = '0;
        n_res_hi    = '0;
        if (r_hit) begin
            if (r_op == OP_INSERT) begin
                n_res_valid = 1'b1;
                n_res_lo    = n_new_lo;
                n_res_hi    = n_new_hi;
            end else if (r_rdata.valid) begin
                n_res_valid = 1'b1;
                n_res_lo    = r_rdata.lo_cm;
                n_res_hi    = r_rdata.hi_cm;
            end
        end
        n_spread   = GEO_W'($signed(n_res_hi)) - GEO_W'($signed(n_res_lo));
        n_obstacle = n_res_valid && (n_spread > $signed(GEO_W'(r_threshold)));
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (upd_fire) begin
            r_out_valid <= 1'b1;
        end else if (i_m_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (upd_fire) begin
            r_out_in_grid    <= r_hit;
            r_out_cell_valid <= n_res_valid;
            r_out_lo         <= n_res_lo;
            r_out_hi         <= n_res_hi;
            r_out_obstacle   <= n_obstacle;
        end
    end

    assign o_m_tvalid = r_out_valid;
    assign o_m_tuser  = r_out_in_grid;
    assign o_m_tdata  = {6'b0, r_out_obstacle, r_out_hi, r_out_lo, r_out_cell_valid};

endmodule

`default_nettype wire

### rtl/lhg_checker.sv
`default_nettype none

module lhg_checker
    import lhg_pkg::*;
(
    input wire logic                  i_clk,
    input wire logic                  i_rst_n,
    input wire logic                  i_s_tvalid,
    input wire logic                  o_s_tready,
    input wire logic                  o_m_tvalid,
    input wire logic                  i_m_tready,
    input wire logic [M_DATA_W-1:0]   o_m_tdata,
    input wire logic                  o_m_tuser
);

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_m_tvalid && !i_m_tready) |=> (o_m_tvalid && $stable(o_m_tdata)
                                         && $stable(o_m_tuser)))
        else $error("result changed while stalled");

    a_one_in_flight: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_s_tvalid && o_s_tready) |=> !o_s_tready)
        else $error("request taken in consecutive cycles");

    a_reset_quiet: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_m_tvalid)
        else $error("result shown after reset");

    a_off_grid_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_m_tvalid && !o_m_tuser) |-> (o_m_tdata == '0))
        else $error("off-grid result not zero");

    a_obstacle_valid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_m_tvalid && o_m_tdata[33]) |-> (o_m_tdata[0] && o_m_tuser))
        else $error("obstacle on an empty cell");

endmodule

bind lidar_height_grid_obstacle_map_unit lhg_checker u_lhg_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_s_tvalid  (i_s_tvalid),
    .o_s_tready  (o_s_tready),
    .o_m_tvalid  (o_m_tvalid),
    .i_m_tready  (i_m_tready),
    .o_m_tdata   (o_m_tdata),
    .o_m_tuser   (o_m_tuser)
);

`default_nettype wire

### tb/tb_lidar_height_grid_obstacle_map_unit.sv
`timescale 1ns / 100ps

module tb_lidar_height_grid_obstacle_map_unit;
    import lhg_pkg::*;

    localparam int GRID_ROWS     = 256;
    localparam int GRID_COLS     = 256;
    localparam int CYCLE_LIMIT   = 400000;
    localparam int HOLD_CYCLES   = 300;
    localparam int SETTLE_CYCLES = 8;
    localparam int HOT_CELLS     = 8;
    localparam int IDLE_PCT      = 14;

    typedef struct packed {
        bit                 in_grid;
        bit                 cell_valid;
        logic [COORD_W-1:0] lo_cm;
        logic [COORD_W-1:0] hi_cm;
        bit                 obstacle;
    } t_map_result;

    logic                  i_clk;
    logic                  i_rst_n     = 1'b0;
    logic                  i_s_tvalid  = 1'b0;
    logic                  o_s_tready;
    logic [S_DATA_W-1:0]   i_s_tdata   = '0;
    logic                  i_s_tuser   = 1'b0;
    logic                  o_m_tvalid;
    logic                  i_m_tready  = 1'b0;
    logic [M_DATA_W-1:0]   o_m_tdata;
    logic                  o_m_tuser;
    logic                  i_cfg_valid = 1'b0;
    logic                  o_cfg_ready;
    logic [CFG_IDX_W-1:0]  i_cfg_index = '0;
    logic [CFG_DATA_W-1:0] i_cfg_data  = '0;

    // register copies
    logic [RANGE_W-1:0]   front_m = RANGE_RST;
    logic [RANGE_W-1:0]   back_m  = RANGE_RST;
    logic [RANGE_W-1:0]   left_m  = RANGE_RST;
    logic [RANGE_W-1:0]   right_m = RANGE_RST;
    logic [CELL_SZ_W-1:0] cell_cm = CELL_RST;
    logic [THR_W-1:0]     thr_cm  = THR_RST;

    // cell store copies
    bit                 cell_seen [GRID_ROWS*GRID_COLS];
    logic [COORD_W-1:0] cell_lo   [GRID_ROWS*GRID_COLS];
    logic [COORD_W-1:0] cell_hi   [GRID_ROWS*GRID_COLS];

    t_map_result pending_cells[$];

    bit   no_idle  = 1'b0;
    bit   hold_off = 1'b0;
    event hold_ev;

    int cycle_count     = 0;
    int mismatches      = 0;
    int requests_sent   = 0;
    int results_seen    = 0;
    int binned_points   = 0;
    int obstacles_seen  = 0;
    int configs_applied = 0;

    lidar_height_grid_obstacle_map_unit #(
        .GRID_ROWS(GRID_ROWS),
        .GRID_COLS(GRID_COLS)
    ) dut (
        .i_clk(i_clk),
        .i_rst_n(i_rst_n),
        .i_s_tvalid(i_s_tvalid),
        .o_s_tready(o_s_tready),
        .i_s_tdata(i_s_tdata),
        .i_s_tuser(i_s_tuser),
        .o_m_tvalid(o_m_tvalid),
        .i_m_tready(i_m_tready),
        .o_m_tdata(o_m_tdata),
        .o_m_tuser(o_m_tuser),
        .i_cfg_valid(i_cfg_valid),
        .o_cfg_ready(o_cfg_ready),
        .i_cfg_index(i_cfg_index),
        .i_cfg_data(i_cfg_data)
    );

    initial begin
        i_clk = 1'b0;
        forever #4 i_clk = ~i_clk;
    end

    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("lidar_height_grid_obstacle_map_unit verification failed");
            $finish;
        end
    end

    function automatic int used_rows();
        int n;
        n = CELLS_PER_M * (int'(front_m) + int'(back_m));
        return (n < GRID_ROWS) ? n : GRID_ROWS;
    endfunction

    function automatic int used_cols();
        int n;
        n = CELLS_PER_M * (int'(left_m) + int'(right_m));
        return (n < GRID_COLS) ? n : GRID_COLS;
    endfunction

    // Bin or look up one request and return the cell as it stands afterwards.
    function automatic t_map_result map_apply(t_opcode op, logic [COORD_W-1:0] x,
            logic [COORD_W-1:0] y, logic [COORD_W-1:0] z,
            logic [QUERY_W-1:0] qrow, logic [QUERY_W-1:0] qcol);
        t_map_result r;
        int rows, cols, row, col, idx;
        r    = '0;
        idx  = -1;
        rows = used_rows();
        cols = used_cols();
        if (op == OP_READ) begin
            row = int'(qrow);
            col = int'(qcol);
            if (row < rows && col < cols)
                idx = row * GRID_COLS + col;
        end else if (cell_cm != 0) begin
            row = CELLS_PER_M * int'(front_m) - 1 - int'($signed(x)) / int'(cell_cm);
            col = CELLS_PER_M * int'(left_m) - 1 - int'($signed(y)) / int'(cell_cm);
            if (row >= 0 && row < rows && col >= 0 && col < cols) begin
                idx = row * GRID_COLS + col;
                binned_points++;
                if (!cell_seen[idx]) begin
                    cell_seen[idx] = 1'b1;
                    cell_lo[idx]   = z;
                    cell_hi[idx]   = z;
                end else begin
                    if ($signed(z) < $signed(cell_lo[idx]))
                        cell_lo[idx] = z;
                    if ($signed(z) > $signed(cell_hi[idx]))
                        cell_hi[idx] = z;
                end
            end
        end
        if (idx >= 0) begin
            r.in_grid = 1'b1;
            if (cell_seen[idx]) begin
                r.cell_valid = 1'b1;
                r.lo_cm      = cell_lo[idx];
                r.hi_cm      = cell_hi[idx];
                r.obstacle   = (int'($signed(cell_hi[idx])) - int'($signed(cell_lo[idx])))
                               > int'(thr_cm);
            end
        end
        return r;
    endfunction

    // Coordinate that truncates to q cells at the current cell size.
    function automatic int coord_for(int q);
        int span, off;
        span = (cell_cm != 0) ? int'(cell_cm) : 1;
        off  = $urandom_range(span - 1);
        if (q > 0)
            return q * span + off;
        if (q < 0)
            return q * span - off;
        return $urandom_range(1) ? off : -off;
    endfunction

    task automatic report_mismatch(input string msg);
        $display("MISMATCH at cycle %0d: %s", cycle_count, msg);
        mismatches++;
    endtask

    task automatic compare_field(input string name, input logic [COORD_W-1:0] got,
            input logic [COORD_W-1:0] want);
        if (got !== want)
            report_mismatch($sformatf("result %0d %s got %0h expected %0h",
                                      results_seen, name, got, want));
    endtask

    always @(posedge i_clk) begin
        t_map_result want;
        if (i_rst_n && o_m_tvalid && i_m_tready) begin
            results_seen++;
            if (pending_cells.size() == 0) begin
                report_mismatch($sformatf("result %0d arrived with no request pending",
                                          results_seen));
            end else begin
                want = pending_cells.pop_front();
                compare_field("in_grid", COORD_W'(o_m_tuser), COORD_W'(want.in_grid));
                compare_field("cell_valid", COORD_W'(o_m_tdata[0]), COORD_W'(want.cell_valid));
                compare_field("min_height_cm", o_m_tdata[16:1], want.lo_cm);
                compare_field("max_height_cm", o_m_tdata[32:17], want.hi_cm);
                compare_field("obstacle", COORD_W'(o_m_tdata[33]), COORD_W'(want.obstacle));
                if (o_m_tdata[33] === 1'b1)
                    obstacles_seen++;
            end
        end
    end

    always @(posedge i_clk) begin
        if (hold_off)
            i_m_tready <= 1'b0;
        else if (no_idle)
            i_m_tready <= 1'b1;
        else
            i_m_tready <= ($urandom_range(99) >= IDLE_PCT);
    end

    always begin
        @(hold_ev);
        hold_off <= 1'b1;
        repeat (HOLD_CYCLES) @(posedge i_clk);
        hold_off <= 1'b0;
    end

    task automatic send_request(input t_opcode op, input logic [COORD_W-1:0] x, y, z,
            input logic [QUERY_W-1:0] qrow, qcol);
        t_map_result expect_cell;
        if (!no_idle) begin
            while ($urandom_range(99) < IDLE_PCT) begin
                i_s_tvalid <= 1'b0;
                @(posedge i_clk);
            end
        end
        i_s_tvalid <= 1'b1;
        i_s_tdata  <= {qcol, qrow, z, y, x};
        i_s_tuser  <= op;
        @(posedge i_clk);
        while (!o_s_tready) @(posedge i_clk);
        expect_cell   = map_apply(op, x, y, z, qrow, qcol);
        pending_cells = {pending_cells, expect_cell};
        requests_sent++;
    endtask

    task automatic insert_point(input int x, y, z);
        send_request(OP_INSERT, COORD_W'(x), COORD_W'(y), COORD_W'(z),
                     QUERY_W'($urandom), QUERY_W'($urandom));
    endtask

    task automatic read_cell(input int row, col);
        send_request(OP_READ, COORD_W'($urandom), COORD_W'($urandom), COORD_W'($urandom),
                     QUERY_W'(row), QUERY_W'(col));
    endtask

    task automatic settle();
        i_s_tvalid <= 1'b0;
        while (pending_cells.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_reg(input t_cfg_reg idx, input int value);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= CFG_DATA_W'(value);
        @(posedge i_clk);
        while (!o_cfg_ready) @(posedge i_clk);
        case (idx)
            CFG_RANGE_FRONT: front_m = RANGE_W'(value);
            CFG_RANGE_BACK:  back_m  = RANGE_W'(value);
            CFG_RANGE_LEFT:  left_m  = RANGE_W'(value);
            CFG_RANGE_RIGHT: right_m = RANGE_W'(value);
            CFG_CELL_SIZE:   cell_cm = CELL_SZ_W'(value);
            CFG_THRESHOLD:   thr_cm  = THR_W'(value);
            default: ;
        endcase
    endtask

    task automatic configure(input int front, back, left, right, size_cm, thr);
        settle();
        write_reg(CFG_RANGE_FRONT, front);
        write_reg(CFG_RANGE_BACK, back);
        write_reg(CFG_RANGE_LEFT, left);
        write_reg(CFG_RANGE_RIGHT, right);
        write_reg(CFG_CELL_SIZE, size_cm);
        write_reg(CFG_THRESHOLD, thr);
        i_cfg_valid <= 1'b0;
        configs_applied++;
    endtask

    // Mostly points aimed at a few hot cells, plus reads of them and random noise.
    task automatic run_mix(input int n);
        int rows, cols, pick, h, xq, yq;
        int hot_r [HOT_CELLS];
        int hot_c [HOT_CELLS];
        logic [COORD_W-1:0] x, y, z;
        rows = used_rows();
        cols = used_cols();
        for (int i = 0; i < HOT_CELLS; i++) begin
            hot_r[i] = (rows > 0) ? $urandom_range(rows - 1) : $urandom_range(GRID_ROWS - 1);
            hot_c[i] = (cols > 0) ? $urandom_range(cols - 1) : $urandom_range(GRID_COLS - 1);
        end
        repeat (n) begin
            h    = $urandom_range(HOT_CELLS - 1);
            pick = $urandom_range(99);
            x    = COORD_W'($urandom);
            y    = COORD_W'($urandom);
            z    = COORD_W'($urandom);
            if (pick < 60) begin
                xq = coord_for(CELLS_PER_M * int'(front_m) - 1 - hot_r[h]);
                yq = coord_for(CELLS_PER_M * int'(left_m) - 1 - hot_c[h]);
                if (xq >= -32768 && xq <= 32767)
                    x = COORD_W'(xq);
                if (yq >= -32768 && yq <= 32767)
                    y = COORD_W'(yq);
                if ($urandom_range(9) != 0)
                    z = COORD_W'(int'($urandom_range(400)) - 200);
                send_request(OP_INSERT, x, y, z, QUERY_W'($urandom), QUERY_W'($urandom));
            end else if (pick < 80) begin
                read_cell(hot_r[h], hot_c[h]);
            end else if (pick < 90) begin
                read_cell($urandom_range(255), $urandom_range(255));
            end else begin
                send_request(OP_INSERT, x, y, z, QUERY_W'($urandom), QUERY_W'($urandom));
            end
        end
    endtask

    // Reset geometry: 100 x 100 cells of 20 cm, origin cell at row 49, column 49.
    task automatic test_directed_defaults();
        read_cell(0, 0);
        read_cell(99, 99);
        read_cell(100, 0);
        read_cell(0, 100);
        read_cell(255, 255);
        insert_point(0, 0, 100);
        insert_point(-19, 19, 120);
        insert_point(19, -19, 121);
        insert_point(-21, 0, 0);
        insert_point(999, -1000, 32767);
        insert_point(980, -1019, -32768);
        insert_point(-1000, 999, 5);
        insert_point(-1020, 0, 1);
        insert_point(1000, 0, 1);
        insert_point(0, -1020, 1);
        insert_point(32767, -32768, 0);
        insert_point(-32768, 32767, -1);
        read_cell(49, 49);
        read_cell(0, 99);
        read_cell(99, 0);
        read_cell(50, 49);
    endtask

    task automatic test_range_extremes();
        configure(0, 0, 0, 0, 20, 0);
        run_mix(30);
        configure(31, 31, 31, 31, 1, 0);
        run_mix(45);
        configure(0, 31, 31, 0, 255, 4095);
        run_mix(45);
        // zero cell size: drop every insert, reads still see earlier cells
        configure(25, 25, 25, 25, 0, 4095);
        insert_point(0, 0, 7);
        read_cell(49, 49);
        read_cell(0, 99);
        read_cell(99, 0);
        run_mix(40);
    endtask

    task automatic test_random_geometry();
        for (int p = 0; p < 5; p++) begin
            configure($urandom_range(1, 25), $urandom_range(1, 25),
                      $urandom_range(1, 25), $urandom_range(1, 25),
                      $urandom_range(1) ? $urandom_range(5, 40) : $urandom_range(1, 255),
                      $urandom_range(1) ? $urandom_range(0, 300) : $urandom_range(0, 4095));
            no_idle <= (p == 2);
            run_mix(300);
        end
        no_idle <= 1'b0;
    endtask

    task automatic test_output_backpressure();
        configure(10, 10, 10, 10, 20, $urandom_range(0, 100));
        -> hold_ev;
        run_mix(150);
    endtask

    initial begin
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;
        test_directed_defaults();
        test_range_extremes();
        test_random_geometry();
        test_output_backpressure();
        settle();
        $display("Sent %0d requests over %0d register settings; %0d points binned,",
                 requests_sent, configs_applied, binned_points);
        $display("%0d results checked, %0d obstacle flags, %0d mismatches.",
                 results_seen, obstacles_seen, mismatches);
        if (mismatches == 0)
            $display("lidar_height_grid_obstacle_map_unit verification clean");
        else
            $display("lidar_height_grid_obstacle_map_unit verification failed");
        $finish;
    end

endmodule

### lidar_height_grid_obstacle_map_unit.f
rtl/lhg_pkg.sv
rtl/lidar_height_grid_obstacle_map_unit.sv
rtl/lhg_checker.sv
tb/tb_lidar_height_grid_obstacle_map_unit.sv
